@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication a |-> b, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

@@ design/c2e_pkg.sv @@
// ----------------------------------------------------------------------------
// c2e_pkg
// Types and constants for the calendar to epoch seconds converter.
// ----------------------------------------------------------------------------
package c2e_pkg;

  // Calendar reading, one per input transaction
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
    logic [3:0]  weekday;
  } reading_t;

  // Result, one per output transaction
  typedef struct packed {
    logic [35:0] epoch_seconds;
    logic        used_default;
  } result_t;

  // Checked work item passed from front to back (March-based month/year)
  typedef struct packed {
    logic [11:0] year_shift;
    logic [3:0]  month_shift;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        used_default;
  } job_t;

  // Range check limits
  localparam logic [5:0]  SEC_MAX     = 6'd59;
  localparam logic [5:0]  MIN_MAX     = 6'd59;
  localparam logic [4:0]  HOUR_MAX    = 5'd24;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
  localparam logic [3:0]  WEEKDAY_MAX = 4'd8;
  localparam logic [3:0]  FEBRUARY    = 4'd2;
  localparam logic [3:0]  MONTH_WRAP  = 4'd10;

  // Substitute reading: 1970-01-01 00:00:00
  localparam logic [4:0]  EPOCH_DAY   = 5'd1;
  localparam logic [3:0]  EPOCH_MONTH = 4'd1;

  // Day count constants
  localparam logic [20:0] DAY_OFFSET    = 21'd719499;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x < 4096
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;

  // Time of day constants
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  // floor(367 * m / 12) for the March-based month m = 1..12
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/c2e_front.sv @@
// ----------------------------------------------------------------------------
// c2e_front
// Accepts readings, checks ranges, substitutes the epoch date on failure and
// shifts month/year to the March-based count. One register stage.
// ----------------------------------------------------------------------------
module c2e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  c2e_pkg::reading_t reading,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output c2e_pkg::job_t     push_item
);
  import c2e_pkg::*;

  logic     f_valid;
  job_t     f_item;
  job_t     item_next;
  logic     reading_ok;
  logic     accept;
  reading_t r;

  // Handshake: hold off only when the staged item cannot enter the queue
  assign busy   = f_valid && q_full;
  assign accept = start && !busy;
  assign push   = f_valid && !q_full;

  // Range check
  assign reading_ok = (reading.second <= SEC_MAX) && (reading.minute <= MIN_MAX)
                   && (reading.hour <= HOUR_MAX) && (reading.day_of_month != '0)
                   && (reading.month_number != '0) && (reading.month_number <= MONTH_MAX)
                   && (reading.year_number >= EPOCH_YEAR)
                   && (reading.weekday != '0) && (reading.weekday <= WEEKDAY_MAX);

  // Substitution and month shift
  always_comb begin
    r = reading;
    if (!reading_ok) begin
      r.second       = '0;
      r.minute       = '0;
      r.hour         = '0;
      r.day_of_month = EPOCH_DAY;
      r.month_number = EPOCH_MONTH;
      r.year_number  = EPOCH_YEAR;
    end
    item_next.day          = r.day_of_month;
    item_next.hour         = r.hour;
    item_next.minute       = r.minute;
    item_next.second       = r.second;
    item_next.used_default = !reading_ok;
    if (r.month_number <= FEBRUARY) begin
      item_next.month_shift = r.month_number + MONTH_WRAP;
      item_next.year_shift  = r.year_number - 12'd1;
    end else begin
      item_next.month_shift = r.month_number - FEBRUARY;
      item_next.year_shift  = r.year_number;
    end
  end

  // Staging register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_item <= item_next;
    end
  end

  assign push_item = f_item;

endmodule

@@ design/c2e_queue.sv @@
// ----------------------------------------------------------------------------
// c2e_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module c2e_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  c2e_pkg::job_t push_item,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output c2e_pkg::job_t pop_item
);
  import c2e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // Storage and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `ASSERT_IMPL(a_no_push_full, clk, rst, full, !push, "push into full queue")
  `ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, !empty, "pop from empty queue")
  `ASSERT_CLK(a_count_range, clk, rst, count <= CNT_W'(DEPTH), "queue count overflow")

endmodule

@@ design/c2e_back.sv @@
// ----------------------------------------------------------------------------
// c2e_back
// Three-stage pipeline: day count terms, day number, epoch seconds.
// Never stalls, so it pops the queue whenever an item is waiting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module c2e_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  c2e_pkg::job_t    pop_item,
  output logic             pop,
  output logic             done,
  output c2e_pkg::result_t result
);
  import c2e_pkg::*;

  // Stage A registers
  logic        va;
  logic [9:0]  a_q4;
  logic [5:0]  a_q100;
  logic [3:0]  a_q400;
  logic [20:0] a_yr365;
  logic [8:0]  a_mdays;
  logic [4:0]  a_day;
  logic [16:0] a_tod;
  logic        a_flag;
  // Stage B registers
  logic        vb;
  logic [19:0] b_days;
  logic [16:0] b_tod;
  logic        b_flag;
  // Stage C registers
  logic        vc;
  result_t     c_res;

  logic [24:0] prod100;
  logic [22:0] prod400;
  logic [20:0] yr365;
  logic [16:0] tod;
  logic [20:0] days_sum;
  logic [35:0] sec_full;

  assign pop = !empty;

  // Stage A: divisions by reciprocal, year days, time of day
  assign prod100 = 25'(pop_item.year_shift) * 25'(RECIP_100);
  assign prod400 = 23'(pop_item.year_shift[11:2]) * 23'(RECIP_100);
  assign yr365   = 21'(pop_item.year_shift) * 21'(DAYS_PER_YEAR);
  assign tod     = 17'(pop_item.hour) * 17'(SEC_PER_HOUR)
                 + 17'(pop_item.minute) * 17'(SEC_PER_MIN)
                 + 17'(pop_item.second);

  // Stage B: day number since epoch (never negative, fits 20 bits)
  assign days_sum = a_yr365 + 21'(a_q4) + 21'(a_q400) + 21'(a_mdays) + 21'(a_day)
                  - 21'(a_q100) - DAY_OFFSET;

  // Stage C: seconds (largest value stays below 2^36)
  assign sec_full = 36'(b_days) * 36'(SEC_PER_DAY) + 36'(b_tod);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= pop;
      vb <= va;
      vc <= vb;
    end
    a_q4    <= pop_item.year_shift[11:2];
    a_q100  <= prod100[24:RECIP_SHIFT];
    a_q400  <= prod400[22:RECIP_SHIFT];
    a_yr365 <= yr365;
    a_mdays <= month_days(pop_item.month_shift);
    a_day   <= pop_item.day;
    a_tod   <= tod;
    a_flag  <= pop_item.used_default;
    b_days  <= days_sum[19:0];
    b_tod   <= a_tod;
    b_flag  <= a_flag;
    c_res.epoch_seconds <= sec_full;
    c_res.used_default  <= b_flag;
  end

  assign done   = vc;
  assign result = c_res;

  `ASSERT_IMPL(a_done_from_pop, clk, rst, done, $past(pop, 3), "result without popped item")
  `ASSERT_IMPL(a_pop_to_done, clk, rst, $past(pop, 3) && !$past(rst, 2), done,
               "popped item lost")
  `ASSERT_IMPL(a_default_zero, clk, rst, done && result.used_default,
               result.epoch_seconds == '0, "substituted reading gave nonzero seconds")

endmodule

@@ design/calendar_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Calendar reading to Unix epoch seconds, with range check and fallback.
// ----------------------------------------------------------------------------
// A reading is taken on a clock edge with start high and busy low; one
// reading per cycle is sustained. Its result appears with done high for a
// single cycle, after passing the front check register, the queue, and the
// first conversion stages (day terms, day number); the third stage (seconds)
// is the output register. The receiver cannot stall, so the back end drains
// the queue every cycle and busy stays low in normal use. Readings that
// fail the range check give zero seconds with used_default set.
module calendar_to_epoch_seconds #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  c2e_pkg::reading_t reading,
  output logic              done,
  output c2e_pkg::result_t  result
);
  import c2e_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_item;
  job_t pop_item;

  c2e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .reading   (reading),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  c2e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  c2e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .pop_item (pop_item),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

endmodule
